[rtl/tcd_pkg.sv]
package tcd_pkg;

  localparam int unsigned LENGTH_LIMIT = 50;
  localparam int unsigned STORED_BYTES = 18;
  localparam int unsigned NUM_WORDS    = STORED_BYTES / 2;
  localparam int unsigned IDX_W        = $clog2(STORED_BYTES);
  localparam int unsigned CNT_W        = 6;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] HDR_BYTE0     = 8'hAA;
  localparam logic [7:0] HDR_BYTE1     = 8'hAF;
  localparam logic [7:0] FUNC_LIMIT    = 8'hF1;
  localparam logic [7:0] LEN_LIMIT     = 8'(LENGTH_LIMIT);

  localparam logic [7:0] FN_CAL        = 8'h01;
  localparam logic [7:0] FN_READ_GAINS = 8'h02;
  localparam logic [7:0] FN_WR_INNER   = 8'h10;
  localparam logic [7:0] FN_WR_OUTER   = 8'h11;
  localparam logic [7:0] SEL_ACCEL     = 8'h01;
  localparam logic [7:0] SEL_GYRO      = 8'h02;
  localparam logic [7:0] SEL_BOTH      = 8'h03;
  localparam logic [7:0] SEL_MAG       = 8'h04;

  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_CAL_ACCEL = 3'd1;
  localparam logic [2:0] ACT_CAL_GYRO  = 3'd2;
  localparam logic [2:0] ACT_CAL_BOTH  = 3'd3;
  localparam logic [2:0] ACT_CAL_MAG   = 3'd4;
  localparam logic [2:0] ACT_RD_GAINS  = 3'd5;
  localparam logic [2:0] ACT_WR_INNER  = 3'd6;
  localparam logic [2:0] ACT_WR_OUTER  = 3'd7;

  // operations handed from the parser to the executer
  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_FUNC  = 3'd2;
  localparam logic [2:0] OP_PAY   = 3'd3;
  localparam logic [2:0] OP_CHECK = 3'd4;

  localparam int unsigned OUT_BITS = 3 + 8 + 8 + 16 * NUM_WORDS;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [2:0]       kind;
    logic [IDX_W-1:0] idx;
    logic             keep;
    logic [7:0]       data;
  } op_t;

  function automatic logic [2:0] decode_action(input logic [7:0] fn, input logic [7:0] first);
    logic [2:0] act;
    act = ACT_NONE;
    unique case (fn)
      FN_CAL: begin
        unique case (first)
          SEL_ACCEL: act = ACT_CAL_ACCEL;
          SEL_GYRO:  act = ACT_CAL_GYRO;
          SEL_BOTH:  act = ACT_CAL_BOTH;
          SEL_MAG:   act = ACT_CAL_MAG;
          default:   act = ACT_NONE;
        endcase
      end
      FN_READ_GAINS: act = (first == SEL_ACCEL) ? ACT_RD_GAINS : ACT_NONE;
      FN_WR_INNER:   act = ACT_WR_INNER;
      FN_WR_OUTER:   act = ACT_WR_OUTER;
      default:       act = ACT_NONE;
    endcase
    return act;
  endfunction

endpackage

[rtl/tcd_front.sv]
module tcd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [7:0]         rx_byte,
  output logic               push,
  output tcd_pkg::op_t       push_op
);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_FUNC = 3'd2;
  localparam logic [2:0] PH_LEN  = 3'd3;
  localparam logic [2:0] PH_PAY  = 3'd4;
  localparam logic [2:0] PH_SUM  = 3'd5;

  logic [2:0]                 phase_r, phase_nxt;
  logic [tcd_pkg::CNT_W-1:0]  left_r, left_nxt;
  logic [tcd_pkg::CNT_W-1:0]  taken_r, taken_nxt;
  logic                       emit;

  always_comb begin
    phase_nxt      = phase_r;
    left_nxt       = left_r;
    taken_nxt      = taken_r;
    emit           = 1'b0;
    push_op.kind   = tcd_pkg::OP_ADD;
    push_op.idx    = taken_r[tcd_pkg::IDX_W-1:0];
    push_op.keep   = (taken_r < tcd_pkg::CNT_W'(tcd_pkg::STORED_BYTES));
    push_op.data   = rx_byte;
    unique case (phase_r)
      PH_HDR1: begin
        if (rx_byte == tcd_pkg::HDR_BYTE1) begin
          phase_nxt = PH_FUNC;
          emit      = 1'b1;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_FUNC: begin
        if (rx_byte < tcd_pkg::FUNC_LIMIT) begin
          phase_nxt    = PH_LEN;
          push_op.kind = tcd_pkg::OP_FUNC;
          emit         = 1'b1;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_LEN: begin
        if (rx_byte < tcd_pkg::LEN_LIMIT) begin
          phase_nxt = PH_PAY;
          left_nxt  = rx_byte[tcd_pkg::CNT_W-1:0];
          taken_nxt = '0;
          emit      = 1'b1;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_PAY: begin
        // zero length never reaches the sum byte
        if (left_r != '0) begin
          push_op.kind = tcd_pkg::OP_PAY;
          emit         = 1'b1;
          taken_nxt    = taken_r + 1'b1;
          left_nxt     = left_r - 1'b1;
          if (left_r == tcd_pkg::CNT_W'(1)) phase_nxt = PH_SUM;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_SUM: begin
        phase_nxt    = PH_HUNT;
        push_op.kind = tcd_pkg::OP_CHECK;
        emit         = 1'b1;
      end
      default: begin
        if (rx_byte == tcd_pkg::HDR_BYTE0) begin
          phase_nxt    = PH_HDR1;
          left_nxt     = '0;
          taken_nxt    = '0;
          push_op.kind = tcd_pkg::OP_START;
          emit         = 1'b1;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
    endcase
  end

  assign push = take & emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      left_r  <= '0;
      taken_r <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      taken_r <= taken_nxt;
    end
  end

endmodule

[rtl/tcd_queue.sv]
module tcd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcd_pkg::op_t  push_op,
  output logic          full,
  input  logic          pop,
  output tcd_pkg::op_t  pop_op,
  output logic          empty
);

  tcd_pkg::op_t                 entries_r [tcd_pkg::QUEUE_DEPTH];
  logic [tcd_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [tcd_pkg::QPTR_W:0]     count_r;

  assign full   = (count_r == (tcd_pkg::QPTR_W+1)'(tcd_pkg::QUEUE_DEPTH));
  assign empty  = (count_r == '0);
  assign pop_op = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

[rtl/tcd_back.sv]
module tcd_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       op_valid,
  input  tcd_pkg::op_t               op,
  output logic                       pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [tcd_pkg::OUT_W-1:0]  out_tdata
);

  logic [7:0]                 sum_r;
  logic [7:0]                 func_r;
  logic [7:0]                 store_r [tcd_pkg::STORED_BYTES];
  logic                       valid_r;
  logic [tcd_pkg::OUT_W-1:0]  data_r, data_nxt;
  logic                       slot_free;
  logic                       is_check;
  logic                       fire;

  assign slot_free = !valid_r || out_tready;
  assign is_check  = (op.kind == tcd_pkg::OP_CHECK);
  assign pop       = op_valid && (!is_check || slot_free);
  assign fire      = pop && is_check && (op.data == sum_r);

  always_comb begin
    data_nxt = '0;
    data_nxt[2:0]   = tcd_pkg::decode_action(func_r, store_r[0]);
    data_nxt[10:3]  = func_r;
    data_nxt[18:11] = sum_r;
    for (int k = 0; k < tcd_pkg::NUM_WORDS; k++) begin
      data_nxt[19 + 16*k +: 16] = {store_r[2*k], store_r[2*k+1]};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      case (op.kind)
        tcd_pkg::OP_START: begin
          sum_r <= op.data;
          for (int i = 0; i < tcd_pkg::STORED_BYTES; i++) store_r[i] <= '0;
        end
        tcd_pkg::OP_ADD: sum_r <= sum_r + op.data;
        tcd_pkg::OP_FUNC: begin
          sum_r  <= sum_r + op.data;
          func_r <= op.data;
        end
        tcd_pkg::OP_PAY: begin
          sum_r <= sum_r + op.data;
          for (int i = 0; i < tcd_pkg::STORED_BYTES; i++) begin
            if (op.keep && op.idx == tcd_pkg::IDX_W'(i)) store_r[i] <= op.data;
          end
        end
        default: ;
      endcase
    end
    if (fire) data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (fire) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

[rtl/telemetry_command_deframer_core.sv]
// channel  dir  beat
// in_      in   tdata[7:0] = rx_byte
// out_     out  tdata = action[2:0], function_code[10:3], frame_sum[18:11],
//                       word_0..word_8 at [34:19]..[162:147], zero to [167:163]
//
// One byte a cycle sustained while the queue has room. The parser decides each byte's role and
// queues an operation (four deep); the executer updates sum and payload bytes and
// loads the result register on a sum byte that matches. With no stall the result
// register loads on the edge after the sum byte is accepted. Synchronous active-low
// reset clears the hunt.
// out_tready low only stalls in_ once the queue fills behind a waiting result.
module telemetry_command_deframer_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // rx_byte
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [tcd_pkg::OUT_W-1:0]  out_tdata   // action, function_code, frame_sum, word_0..8
);

  logic          take;
  logic          push;
  tcd_pkg::op_t  push_op;
  logic          full;
  logic          pop;
  tcd_pkg::op_t  pop_op;
  logic          empty;

  assign in_tready = !full;
  assign take      = in_tvalid && in_tready;

  tcd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_tdata),
    .push    (push),
    .push_op (push_op)
  );

  tcd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .full    (full),
    .pop     (pop),
    .pop_op  (pop_op),
    .empty   (empty)
  );

  tcd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_valid   (!empty),
    .op         (pop_op),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[sim/tcd_checker.sv]
module tcd_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [7:0]                in_tdata,    // rx_byte
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [tcd_pkg::OUT_W-1:0] out_tdata,   // action, function_code, frame_sum, word_0..8
  output int unsigned               errors,
  output int unsigned               frames_pending,
  output int unsigned               frames_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import tcd_pkg::*;

  typedef enum logic [2:0] {
    RX_HUNT, RX_SYNC, RX_FUNC, RX_LEN, RX_PAYLOAD, RX_SUM
  } rx_phase_e;

  // packed so that action lands in the low bits, as on out_tdata
  typedef struct packed {
    logic [NUM_WORDS-1:0][15:0] words;
    logic [7:0]                 sum;
    logic [7:0]                 fn;
    logic [2:0]                 act;
  } frame_result_t;

  rx_phase_e     phase;
  logic [5:0]    left;
  logic [5:0]    taken;
  logic [7:0]    sum;
  logic [7:0]    fn;
  logic [7:0]    payload [STORED_BYTES];
  frame_result_t frames_due[$];
  int unsigned   err_cnt;
  int unsigned   done_cnt;

  initial begin
    errors         = 0;
    frames_pending = 0;
    frames_checked = 0;
    err_cnt        = 0;
    done_cnt       = 0;
  end

  function automatic logic [2:0] action_of(input logic [7:0] code, input logic [7:0] sel);
    if (code == FN_WR_INNER) return ACT_WR_INNER;
    if (code == FN_WR_OUTER) return ACT_WR_OUTER;
    if (code == FN_READ_GAINS) return (sel == SEL_ACCEL) ? ACT_RD_GAINS : ACT_NONE;
    if (code != FN_CAL) return ACT_NONE;
    if (sel == SEL_ACCEL) return ACT_CAL_ACCEL;
    if (sel == SEL_GYRO) return ACT_CAL_GYRO;
    if (sel == SEL_BOTH) return ACT_CAL_BOTH;
    if (sel == SEL_MAG) return ACT_CAL_MAG;
    return ACT_NONE;
  endfunction

  task automatic clear_frame();
    left  = '0;
    taken = '0;
    foreach (payload[i]) payload[i] = '0;
  endtask

  task automatic take_byte(input logic [7:0] b);
    frame_result_t r;
    case (phase)
      RX_SYNC: begin
        if (b == HDR_BYTE1) begin
          phase = RX_FUNC;
          sum   = sum + b;
        end else begin
          phase = RX_HUNT;
        end
      end
      RX_FUNC: begin
        if (b < FUNC_LIMIT) begin
          phase = RX_LEN;
          fn    = b;
          sum   = sum + b;
        end else begin
          phase = RX_HUNT;
        end
      end
      RX_LEN: begin
        if (b < LEN_LIMIT) begin
          phase = RX_PAYLOAD;
          left  = b[5:0];
          taken = '0;
          sum   = sum + b;
        end else begin
          phase = RX_HUNT;
        end
      end
      RX_PAYLOAD: begin
        // zero length lands here with nothing to take and drops the frame
        if (left != 0) begin
          if (taken < STORED_BYTES) payload[taken] = b;
          taken = taken + 1'b1;
          left  = left - 1'b1;
          sum   = sum + b;
          if (left == 0) phase = RX_SUM;
        end else begin
          phase = RX_HUNT;
        end
      end
      RX_SUM: begin
        phase = RX_HUNT;
        if (b == sum) begin
          r.act = action_of(fn, payload[0]);
          r.fn  = fn;
          r.sum = sum;
          for (int k = 0; k < NUM_WORDS; k++) r.words[k] = {payload[2*k], payload[2*k+1]};
          frames_due.push_back(r);
        end
      end
      default: begin
        // a byte breaking a frame is consumed, so it never restarts one here
        if (b == HDR_BYTE0) begin
          phase = RX_SYNC;
          sum   = b;
          clear_frame();
        end else begin
          phase = RX_HUNT;
        end
      end
    endcase
  endtask

  task automatic check_field(input string what, input logic [15:0] exp, input logic [15:0] got);
    if (exp !== got) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("frame %0d: %s mismatch, expected %h, got %h", done_cnt, what, exp, got);
    end
  endtask

  always @(posedge clk) begin
    frame_result_t exp;
    if (!rst_n) begin
      phase = RX_HUNT;
      sum   = '0;
      fn    = '0;
      clear_frame();
      frames_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (frames_due.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("result beat with nothing expected: %h", out_tdata);
        end else begin
          exp = frames_due.pop_front();
          check_field("action", 16'(exp.act), 16'(out_tdata[2:0]));
          check_field("function_code", 16'(exp.fn), 16'(out_tdata[10:3]));
          check_field("frame_sum", 16'(exp.sum), 16'(out_tdata[18:11]));
          for (int k = 0; k < NUM_WORDS; k++)
            check_field($sformatf("word_%0d", k), exp.words[k], out_tdata[19 + 16*k +: 16]);
        end
        done_cnt++;
      end
      if (in_tvalid && in_tready) take_byte(in_tdata);
    end
    errors         <= err_cnt;
    frames_pending <= frames_due.size();
    frames_checked <= done_cnt;
  end

endmodule

[sim/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tcd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned PHASE_BYTES  = 420;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;

  int unsigned errors;
  int unsigned frames_pending;
  int unsigned frames_checked;
  int unsigned bytes_sent  = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  int unsigned hold_req    = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;

  always #5 clk = ~clk;

  telemetry_command_deframer_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  tcd_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .errors         (errors),
    .frames_pending (frames_pending),
    .frames_checked (frames_checked)
  );

  // receiver: random stalls, plus a long hold-off whenever one is requested
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // sel < 0 leaves the first payload byte random
  task automatic send_frame(input logic [7:0] fn, input logic [5:0] len, input int sel,
                            input bit sum_ok);
    logic [7:0] acc;
    logic [7:0] b;
    acc = HDR_BYTE0 + HDR_BYTE1 + fn + {2'b00, len};
    send_byte(HDR_BYTE0);
    send_byte(HDR_BYTE1);
    send_byte(fn);
    send_byte({2'b00, len});
    for (int i = 0; i < len; i++) begin
      b   = (i == 0 && sel >= 0) ? 8'(sel) : 8'($urandom_range(0, 255));
      acc = acc + b;
      send_byte(b);
    end
    if (!sum_ok) acc = acc + 8'($urandom_range(1, 255));
    send_byte(acc);
  endtask

  task automatic send_random_frame();
    int         r;
    int         sel;
    logic [7:0] fn;
    logic [5:0] len;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end else if (r < 11) begin
      send_byte(HDR_BYTE0);
      send_byte(8'($urandom_range(0, 255)));
    end else if (r < 14) begin
      send_byte(HDR_BYTE0);
      send_byte(HDR_BYTE1);
      send_byte(8'($urandom_range(FUNC_LIMIT, 8'hFF)));
    end else if (r < 17) begin
      send_byte(HDR_BYTE0);
      send_byte(HDR_BYTE1);
      send_byte(8'($urandom_range(0, 8'hF0)));
      send_byte(8'($urandom_range(LEN_LIMIT, 8'hFF)));
    end else begin
      case ($urandom_range(0, 9))
        0, 1:    fn = FN_CAL;
        2:       fn = FN_READ_GAINS;
        3:       fn = FN_WR_INNER;
        4:       fn = FN_WR_OUTER;
        5:       fn = 8'hF0;
        6:       fn = 8'h00;
        default: fn = 8'($urandom_range(0, 8'hF0));
      endcase
      r = $urandom_range(0, 99);
      if (r < 2)       len = 6'd0;
      else if (r < 5)  len = 6'(LENGTH_LIMIT - 1);
      else if (r < 75) len = 6'($urandom_range(1, 8));
      else if (r < 92) len = 6'($urandom_range(9, 20));
      else             len = 6'($urandom_range(21, LENGTH_LIMIT - 2));
      sel = ($urandom_range(0, 9) < 6) ? int'($urandom_range(0, 5)) : -1;
      send_frame(fn, len, sel, $urandom_range(0, 99) < 88);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned phase_start;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // second header byte replaced by a fresh 0xAA: no restart, the rest is noise
    send_byte(HDR_BYTE0);
    send_byte(HDR_BYTE0);
    send_byte(HDR_BYTE1);
    send_byte(FN_CAL);
    send_frame(FN_CAL, 6'd1, SEL_GYRO, 1'b1);
    // zero length: the byte after the length drops the frame
    send_frame(8'hF0, 6'd0, -1, 1'b1);
    send_byte(HDR_BYTE0);
    send_byte(HDR_BYTE1);
    send_byte(FUNC_LIMIT);
    send_byte(HDR_BYTE0);
    send_byte(HDR_BYTE1);
    send_byte(FN_WR_INNER);
    send_byte(LEN_LIMIT);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 82; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      if (p == 0) begin
        // back-to-back short frames against a blocked output fill the queue
        hold_req++;
        repeat (30) send_frame(FN_WR_OUTER, 6'd1, -1, 1'b1);
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_random_frame();
      wait_drained();
    end

    $display("%0d bytes sent in four idle/stall mixes with one long output hold-off,",
             bytes_sent);
    $display("%0d decoded frames compared field by field", frames_checked);
    if (errors == 0 && frames_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d frames outstanding", errors, frames_pending);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
